// ----- rtl/cba_pkg.sv -----
package cba_pkg;

  // Word and CRC geometry
  localparam int WORD_BITS        = 128;
  localparam int HALF_BITS        = 64;
  localparam int CRC_LEN          = 24;
  localparam logic [CRC_LEN:0] GEN_POLY = 25'h1800063;
  localparam int MAX_FILLER_WORDS = 62;
  localparam int FILL_W           = $clog2(MAX_FILLER_WORDS + 1);
  localparam int CNT_W            = $clog2(MAX_FILLER_WORDS + 2);
  localparam int SHIFT_W          = $clog2(WORD_BITS + 1);
  localparam int WIDX_W           = 7;
  localparam int BIDX_W           = 6;

  // LDPC base graph factors
  localparam int BG1_FACTOR = 22;
  localparam int BG2_FACTOR = 10;

  // Register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int NCB_W  = 6;
  localparam int KP_W   = 14;
  localparam int ZC_W   = 9;

  typedef enum logic [1:0] {
    REG_NUM_CB     = 2'd0,
    REG_BLOCK_SIZE = 2'd1,
    REG_BG2        = 2'd2,
    REG_ZC         = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [NCB_W-1:0] num_cb;
    logic [KP_W-1:0]  block_size;
    logic             bg2;
    logic [ZC_W-1:0]  zc;
  } cfg_t;

  // Input stage contents handed to the emit stage
  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] data;
    logic                 is_last;
    logic                 crc_end;
    logic [SHIFT_W-1:0]   free_bits;
    logic [FILL_W-1:0]    fill;
    logic [CRC_LEN-1:0]   crc_in;
    logic [CRC_LEN-1:0]   pow_fac;
  } stage_t;

  // Powers of x modulo the CRC24B polynomial
  localparam int POW_MAX = WORD_BITS + CRC_LEN;
  typedef logic [POW_MAX:0][CRC_LEN-1:0] pow_tbl_t;

  function automatic pow_tbl_t build_pow_tbl();
    pow_tbl_t         tbl;
    logic [CRC_LEN:0] p;
    p = {{CRC_LEN{1'b0}}, 1'b1};
    for (int e = 0; e <= POW_MAX; e++) begin
      tbl[e] = p[CRC_LEN-1:0];
      p = {p[CRC_LEN-1:0], 1'b0};
      if (p[CRC_LEN]) p = p ^ GEN_POLY;
    end
    return tbl;
  endfunction

  localparam pow_tbl_t POW_TBL = build_pow_tbl();

  // Advance the remainder over one full word, MSB first
  function automatic logic [CRC_LEN-1:0] crc_word(input logic [CRC_LEN-1:0] r,
                                                  input logic [WORD_BITS-1:0] w);
    logic [CRC_LEN-1:0] acc;
    acc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) acc = acc ^ POW_TBL[i];
    end
    for (int j = 0; j < CRC_LEN; j++) begin
      if (r[j]) acc = acc ^ POW_TBL[WORD_BITS + j];
    end
    return acc;
  endfunction

  // Remainder of a right-aligned word followed by 24 zero bits, from zero
  function automatic logic [CRC_LEN-1:0] crc_aug(input logic [WORD_BITS-1:0] v);
    logic [CRC_LEN-1:0] acc;
    acc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) acc = acc ^ POW_TBL[i + CRC_LEN];
    end
    return acc;
  endfunction

  // Carry-less product of two residues, reduced modulo the polynomial
  function automatic logic [CRC_LEN-1:0] clmul_mod(input logic [CRC_LEN-1:0] a,
                                                   input logic [CRC_LEN-1:0] b);
    logic [2*CRC_LEN-2:0] prod;
    logic [CRC_LEN-1:0]   acc;
    prod = '0;
    acc  = '0;
    for (int i = 0; i < CRC_LEN; i++) begin
      if (b[i]) prod = prod ^ ((2*CRC_LEN-1)'(a) << i);
    end
    for (int k = 0; k < 2*CRC_LEN-1; k++) begin
      if (prod[k]) acc = acc ^ POW_TBL[k];
    end
    return acc;
  endfunction

endpackage

// ----- rtl/cba_regs.sv -----
module cba_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cba_pkg::ADDR_W-1:0]  paddr,
  input  logic [cba_pkg::DATA_W-1:0]  pwdata,
  output logic [cba_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cba_pkg::cfg_t               cfg
);

  cba_pkg::cfg_t    cfg_r;
  cba_pkg::cfg_reg_t reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cba_pkg::cfg_reg_t'(paddr[cba_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Write one register per access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_cb     <= 6'd1;
      cfg_r.block_size <= 14'd8448;
      cfg_r.bg2        <= 1'b0;
      cfg_r.zc         <= 9'd384;
    end else if (wr_en) begin
      case (reg_sel)
        cba_pkg::REG_NUM_CB:     cfg_r.num_cb     <= pwdata[cba_pkg::NCB_W-1:0];
        cba_pkg::REG_BLOCK_SIZE: cfg_r.block_size <= pwdata[cba_pkg::KP_W-1:0];
        cba_pkg::REG_BG2:        cfg_r.bg2        <= pwdata[0];
        cba_pkg::REG_ZC:         cfg_r.zc         <= pwdata[cba_pkg::ZC_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      cba_pkg::REG_NUM_CB:     prdata = cba_pkg::DATA_W'(cfg_r.num_cb);
      cba_pkg::REG_BLOCK_SIZE: prdata = cba_pkg::DATA_W'(cfg_r.block_size);
      cba_pkg::REG_BG2:        prdata = cba_pkg::DATA_W'(cfg_r.bg2);
      cba_pkg::REG_ZC:         prdata = cba_pkg::DATA_W'(cfg_r.zc);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- rtl/cba_ctrl.sv -----
module cba_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cba_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cba_pkg::WORD_BITS-1:0]  in_data,
  input  logic                           stage_b_free,
  output cba_pkg::stage_t                stage_a
);

  cba_pkg::stage_t              stage_a_r;
  cba_pkg::stage_t              stage_a_nxt;
  logic [cba_pkg::CRC_LEN-1:0]  crc_r, crc_nxt;
  logic [cba_pkg::WIDX_W-1:0]   widx_r, widx_nxt;
  logic [cba_pkg::BIDX_W-1:0]   bidx_r, bidx_nxt, bidx_inc;

  logic                         accept, a_take, crc_on, is_last;
  logic [cba_pkg::KP_W-1:0]     payload, kk, zc_ext, diff;
  logic [cba_pkg::KP_W:0]       round_up, span;
  logic [cba_pkg::SHIFT_W-1:0]  bursts, bursts_m1, free_bits;
  logic [cba_pkg::KP_W-8:0]     fill_raw;
  logic [cba_pkg::FILL_W-1:0]   fill;

  assign a_take   = stage_a_r.valid && stage_b_free;
  assign in_ready = !stage_a_r.valid || a_take;
  assign accept   = in_valid && in_ready;
  assign stage_a  = stage_a_r;

  // Block geometry from the current configuration
  always_comb begin
    crc_on = cfg.num_cb > cba_pkg::NCB_W'(1);
    if (!crc_on) begin
      payload = cfg.block_size;
    end else if (cfg.block_size < cba_pkg::KP_W'(cba_pkg::CRC_LEN)) begin
      payload = '0;
    end else begin
      payload = cfg.block_size - cba_pkg::KP_W'(cba_pkg::CRC_LEN);
    end
    round_up  = {1'b0, payload} + (cba_pkg::KP_W+1)'(cba_pkg::WORD_BITS - 1);
    bursts    = (payload == '0) ? cba_pkg::SHIFT_W'(1) : round_up[cba_pkg::KP_W:7];
    bursts_m1 = bursts - cba_pkg::SHIFT_W'(1);
    is_last   = {1'b0, widx_r} >= bursts_m1;
    span      = {bursts, 7'b0} - {1'b0, payload};
    free_bits = span[cba_pkg::SHIFT_W-1:0];
  end

  // Filler length from the LDPC information size
  always_comb begin
    zc_ext = cba_pkg::KP_W'(cfg.zc);
    kk     = cfg.bg2 ? cba_pkg::KP_W'(zc_ext * cba_pkg::KP_W'(cba_pkg::BG2_FACTOR))
                     : cba_pkg::KP_W'(zc_ext * cba_pkg::KP_W'(cba_pkg::BG1_FACTOR));
    diff   = kk - cfg.block_size;
    fill_raw = (kk > cfg.block_size) ? diff[cba_pkg::KP_W-1:7] : '0;
    if (fill_raw > (cba_pkg::KP_W-7)'(cba_pkg::MAX_FILLER_WORDS)) begin
      fill = cba_pkg::FILL_W'(cba_pkg::MAX_FILLER_WORDS);
    end else begin
      fill = fill_raw[cba_pkg::FILL_W-1:0];
    end
  end

  // Running remainder and block position
  always_comb begin
    crc_nxt  = crc_r;
    widx_nxt = widx_r;
    bidx_nxt = bidx_r;
    bidx_inc = bidx_r + cba_pkg::BIDX_W'(1);
    if (accept) begin
      if (!is_last) begin
        if (crc_on) crc_nxt = cba_pkg::crc_word(crc_r, in_data);
        widx_nxt = widx_r + cba_pkg::WIDX_W'(1);
      end else begin
        crc_nxt  = '0;
        widx_nxt = '0;
        bidx_nxt = (bidx_inc >= cfg.num_cb) ? '0 : bidx_inc;
      end
    end
  end

  // Capture the beat with everything the emit stage needs
  always_comb begin
    stage_a_nxt.valid     = 1'b1;
    stage_a_nxt.data      = in_data;
    stage_a_nxt.is_last   = is_last;
    stage_a_nxt.crc_end   = crc_on && is_last;
    stage_a_nxt.free_bits = free_bits;
    stage_a_nxt.fill      = is_last ? fill : '0;
    stage_a_nxt.crc_in    = crc_r;
    stage_a_nxt.pow_fac   =
      cba_pkg::POW_TBL[cba_pkg::SHIFT_W'(cba_pkg::POW_MAX - int'(free_bits))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      widx_r <= '0;
      bidx_r <= '0;
    end else begin
      crc_r  <= crc_nxt;
      widx_r <= widx_nxt;
      bidx_r <= bidx_nxt;
    end
  end

  // Hold the input register until the emit stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_a_r.valid <= 1'b0;
    end else if (accept) begin
      stage_a_r <= stage_a_nxt;
    end else if (a_take) begin
      stage_a_r.valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/cba_emit.sv -----
module cba_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cba_pkg::stage_t                stage_a,
  output logic                           stage_b_free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cba_pkg::WORD_BITS-1:0]  out_data,
  output logic                           out_block_last,
  output logic                           out_run_end
);

  localparam int WB = cba_pkg::WORD_BITS;
  localparam int CL = cba_pkg::CRC_LEN;

  // Emit stage registers
  logic                         b_valid_r;
  logic [WB-1:0]                b_data_r;
  logic [CL-1:0]                b_crc_r;
  logic [cba_pkg::SHIFT_W-1:0]  b_shift_r;
  logic                         b_spill_r;
  logic                         b_block_r;
  logic [cba_pkg::CNT_W-1:0]    b_last_idx_r;
  logic [cba_pkg::CNT_W-1:0]    b_cnt_r;

  // Output register
  logic                         out_valid_r;
  logic [WB-1:0]                out_data_r;
  logic                         out_block_last_r;
  logic                         out_run_end_r;

  logic                         load_b, emit, beat_last, out_free;
  logic [CL-1:0]                crc_fin;
  logic [cba_pkg::SHIFT_W-1:0]  shift_eff;
  logic                         spill;
  logic [WB+CL-1:0]             crc_pos;
  logic [WB-1:0]                keep_mask, word_first, word_spill, word_sel;

  assign out_free     = !out_valid_r || out_ready;
  assign emit         = b_valid_r && out_free;
  assign beat_last    = b_cnt_r == b_last_idx_r;
  assign stage_b_free = !b_valid_r || (emit && beat_last);
  assign load_b       = stage_a.valid && stage_b_free;

  // Final remainder: carried state shifted past the tail bits, plus the tail
  always_comb begin
    shift_eff = stage_a.crc_end ? stage_a.free_bits : '0;
    spill     = stage_a.crc_end && (stage_a.free_bits < cba_pkg::SHIFT_W'(CL));
    if (stage_a.crc_end) begin
      crc_fin = cba_pkg::clmul_mod(stage_a.crc_in, stage_a.pow_fac)
              ^ cba_pkg::crc_aug(stage_a.data >> stage_a.free_bits);
    end else begin
      crc_fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_cnt_r   <= '0;
    end else if (load_b) begin
      b_valid_r <= 1'b1;
      b_cnt_r   <= '0;
    end else if (emit) begin
      if (beat_last) begin
        b_valid_r <= 1'b0;
        b_cnt_r   <= '0;
      end else begin
        b_cnt_r <= b_cnt_r + cba_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_data_r     <= stage_a.data;
      b_crc_r      <= crc_fin;
      b_shift_r    <= shift_eff;
      b_spill_r    <= spill;
      b_block_r    <= stage_a.is_last;
      b_last_idx_r <= cba_pkg::CNT_W'(spill) + cba_pkg::CNT_W'(stage_a.fill);
    end
  end

  // Pack the CRC right after the last payload bit, spilling into a second word
  always_comb begin
    crc_pos    = {{WB{1'b0}}, b_crc_r} << b_shift_r;
    keep_mask  = {WB{1'b1}} << b_shift_r;
    word_first = (b_data_r & keep_mask) | crc_pos[WB+CL-1:CL];
    word_spill = {crc_pos[CL-1:0], {(WB-CL){1'b0}}};
    if (b_cnt_r == '0) begin
      word_sel = word_first;
    end else if (b_spill_r && (b_cnt_r == cba_pkg::CNT_W'(1))) begin
      word_sel = word_spill;
    end else begin
      word_sel = '0;
    end
  end

  // Advance the output register whenever it is empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r       <= word_sel;
      out_run_end_r    <= beat_last;
      out_block_last_r <= beat_last && b_block_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_block_last = out_block_last_r;
  assign out_run_end    = out_run_end_r;

endmodule

// ----- rtl/code_block_crc24_attach_top.sv -----
// CRC24B code block attachment on a stream of 128-bit words.
// Input channel: in_valid/in_ready with in_data_high (bits 127..64, sent
// first) and in_data_low. Output channel: out_valid/out_ready with the two
// data halves, out_block_last on the final beat of a code block (filler
// included) and out_run_end on the last beat caused by one input word.
// Configuration: APB registers num_code_blocks, block_size_bits,
// base_graph_two and lifting_size at byte addresses 0, 4, 8 and 12.
// Path: a word accepted on the input passes through the input register,
// the emit register and the output register before it appears.
// Throughput: one word per cycle inside a code block while out_ready is high.
// The final word of a block holds the emit stage for 1 + spill + filler beats
// (up to 64): one beat for the word, one more when the CRC spills past it,
// one per filler word, all through the single output register.
// Reset clears the remainder, the word and block counters and all valid
// flags and restores the register defaults. When out_ready is low the output
// beat holds and the emit stage waits; the input register takes a word only
// while empty or being emptied, so in a full pipe in_ready drops at once.
module code_block_crc24_attach_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cba_pkg::HALF_BITS-1:0]  in_data_high,
  input  logic [cba_pkg::HALF_BITS-1:0]  in_data_low,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cba_pkg::HALF_BITS-1:0]  out_data_high,
  output logic [cba_pkg::HALF_BITS-1:0]  out_data_low,
  output logic                           out_block_last,
  output logic                           out_run_end,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cba_pkg::ADDR_W-1:0]     paddr,
  input  logic [cba_pkg::DATA_W-1:0]     pwdata,
  output logic [cba_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  cba_pkg::cfg_t                  cfg;
  cba_pkg::stage_t                stage_a;
  logic                           stage_b_free;
  logic [cba_pkg::WORD_BITS-1:0]  out_data;

  cba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cba_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      ({in_data_high, in_data_low}),
    .stage_b_free (stage_b_free),
    .stage_a      (stage_a)
  );

  cba_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .stage_a        (stage_a),
    .stage_b_free   (stage_b_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .out_block_last (out_block_last),
    .out_run_end    (out_run_end)
  );

  assign out_data_high = out_data[cba_pkg::WORD_BITS-1:cba_pkg::HALF_BITS];
  assign out_data_low  = out_data[cba_pkg::HALF_BITS-1:0];

  // A block always closes on the last beat of a run
  a_block_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_last |-> out_run_end)
    else $error("block_last without run_end");

  // A multi-beat run leaves no gap on the output
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_end |=> out_valid)
    else $error("gap inside an output run");

  // Reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !stage_a.valid)
    else $error("pipeline not empty after reset");

  // A filled input register is taken as soon as the emit stage frees up
  a_stage_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    stage_a.valid && stage_b_free |-> in_ready)
    else $error("input stage stalled with emit stage free");

endmodule

// ----- test/tb_code_block_crc24_attach_top.sv -----
`timescale 1ns / 100ps

module tb_code_block_crc24_attach_top;

  localparam logic [24:0] CRC24B_POLY    = 25'h1800063;
  localparam int          FILL_CAP       = 62;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          RAND_PHASES    = 8;
  localparam int          PHASE_WORDS    = 25;
  localparam logic [63:0] ONES           = 64'hFFFF_FFFF_FFFF_FFFF;

  // One output beat as the block should present it
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        blast;
    logic        rend;
  } beat_t;

  // One directed row: register settings, the word, and an optional typed beat
  typedef struct packed {
    logic [5:0]  ncb;
    logic [13:0] kp;
    logic        bg2;
    logic [8:0]  zc;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        typed;
    beat_t       tbeat;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_high = '0;
  logic [63:0] in_data_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_data_high;
  logic [63:0] out_data_low;
  logic        out_block_last;
  logic        out_run_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [cba_pkg::ADDR_W-1:0] paddr = '0;
  logic [cba_pkg::DATA_W-1:0] pwdata = '0;
  logic [cba_pkg::DATA_W-1:0] prdata;
  logic        pready;

  // Register copies and block state as the predictor sees them
  logic [5:0]  ncb_q = 6'd1;
  logic [13:0] kp_q = 14'd8448;
  logic        bg2_q = 1'b0;
  logic [8:0]  zc_q = 9'd384;
  logic [23:0] crc_rem = '0;
  logic [6:0]  word_idx = '0;
  logic [5:0]  blk_idx = '0;

  beat_t    exp_beats[$];
  dir_row_t dir_rows[$];
  beat_t    mon_want;
  int       err_cnt = 0;
  int       burst_left = 0;
  int       idle_cycles;
  int       rx_cycle = 0;
  int       rx_mode = 0;

  code_block_crc24_attach_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_high  (in_data_high),
    .in_data_low   (in_data_low),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_high (out_data_high),
    .out_data_low  (out_data_low),
    .out_block_last(out_block_last),
    .out_run_end   (out_run_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
    err_cnt++;
  endtask

  // Advance the CRC24B register by one bit
  function automatic logic [23:0] crc24b_bit(input logic [23:0] r, input logic b);
    logic [24:0] t;
    t = {r, b};
    if (t[24]) t = t ^ CRC24B_POLY;
    return t[23:0];
  endfunction

  // Work out the beats one accepted word causes and queue them
  task automatic predict_attach(input logic [63:0] hi, input logic [63:0] lo,
                                input logic typed, input beat_t tbeat);
    logic         crc_on;
    int           payload, words, widx, kk, fill, n, i;
    logic [127:0] w, w2;
    logic [23:0]  r;
    beat_t        run_q[$];
    beat_t        b;
    w = {hi, lo};
    r = crc_rem;
    crc_on = (ncb_q > 6'd1);
    payload = kp_q;
    if (crc_on) payload = payload - 24;
    if (payload < 0) payload = 0;
    words = (payload + 127) / 128;
    if (words < 1) words = 1;
    widx = word_idx;

    // Inner word of a block: pass through, fold into the remainder
    if (widx < words - 1) begin
      if (crc_on) begin
        for (i = 127; i >= 0; i--) r = crc24b_bit(r, w[i]);
      end
      crc_rem = r;
      word_idx = word_idx + 7'd1;
      b = {hi, lo, 1'b0, 1'b1};
      if (typed) b = tbeat;
      exp_beats.push_back(b);
      return;
    end

    kk = zc_q;
    kk = kk * (bg2_q ? 10 : 22);
    fill = (kk > int'(kp_q)) ? (kk - int'(kp_q)) / 128 : 0;
    if (fill > FILL_CAP) fill = FILL_CAP;

    if (crc_on) begin
      n = 128 * words - payload;
      for (i = 127; i >= n; i--) r = crc24b_bit(r, w[i]);
      for (i = 0; i < 24; i++) r = crc24b_bit(r, 1'b0);
      if (n == 0) begin
        // Final word full: CRC goes to the top of an extra word
        run_q.push_back({w[127:64], w[63:0], 1'b0, 1'b0});
        w2 = {r, 104'b0};
        run_q.push_back({w2[127:64], w2[63:0], fill == 0, 1'b0});
      end else if (n >= 24) begin
        w = w & ({128{1'b1}} << n);
        w = w | (128'(r) << (n - 24));
        run_q.push_back({w[127:64], w[63:0], fill == 0, 1'b0});
      end else begin
        // Fewer than 24 free bits: split the CRC across two words
        w = w & ({128{1'b1}} << n);
        w = w | 128'(r >> (24 - n));
        run_q.push_back({w[127:64], w[63:0], 1'b0, 1'b0});
        w2 = 128'(r & ((24'd1 << (24 - n)) - 24'd1)) << (104 + n);
        run_q.push_back({w2[127:64], w2[63:0], fill == 0, 1'b0});
      end
    end else begin
      run_q.push_back({hi, lo, fill == 0, 1'b0});
    end

    for (i = 1; i <= fill; i++) run_q.push_back({64'd0, 64'd0, i == fill, 1'b0});
    b = run_q[run_q.size() - 1];
    b.rend = 1'b1;
    run_q[run_q.size() - 1] = b;
    if (typed) run_q[0] = tbeat;
    foreach (run_q[j]) exp_beats.push_back(run_q[j]);

    crc_rem = '0;
    word_idx = '0;
    blk_idx = blk_idx + 6'd1;
    if (blk_idx >= ncb_q) blk_idx = '0;
  endtask

  // Offer one word; open a new burst, often after a random gap, when the old one runs out
  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo,
                           input logic typed, input beat_t tbeat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 10);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_high <= hi;
    in_data_low  <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_attach(hi, lo, typed, tbeat);
    @(negedge clk);
  endtask

  // Hold off the sender until every queued beat has arrived
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (exp_beats.size() != 0) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic cfg_access(input cba_pkg::cfg_reg_t idx, input logic wr,
                            input logic [31:0] wdata, input logic [31:0] rexp);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== rexp)
      report_mismatch("register readback", 64'(rexp), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drain, then write all four registers with junk above the field and read back
  task automatic set_config(input logic [5:0] ncb, input logic [13:0] kp,
                            input logic bg2, input logic [8:0] zc);
    wait_drain();
    cfg_access(cba_pkg::REG_NUM_CB, 1'b1, ($urandom & ~32'h3F) | ncb, '0);
    ncb_q = ncb;
    cfg_access(cba_pkg::REG_NUM_CB, 1'b0, '0, {26'd0, ncb_q});
    cfg_access(cba_pkg::REG_BLOCK_SIZE, 1'b1, ($urandom & ~32'h3FFF) | kp, '0);
    kp_q = kp;
    cfg_access(cba_pkg::REG_BLOCK_SIZE, 1'b0, '0, {18'd0, kp_q});
    cfg_access(cba_pkg::REG_BG2, 1'b1, ($urandom & ~32'h1) | bg2, '0);
    bg2_q = bg2;
    cfg_access(cba_pkg::REG_BG2, 1'b0, '0, {31'd0, bg2_q});
    cfg_access(cba_pkg::REG_ZC, 1'b1, ($urandom & ~32'h1FF) | zc, '0);
    zc_q = zc;
    cfg_access(cba_pkg::REG_ZC, 1'b0, '0, {23'd0, zc_q});
  endtask

  task automatic add_row(input logic [5:0] ncb, input logic [13:0] kp, input logic bg2,
                         input logic [8:0] zc, input logic [63:0] hi, input logic [63:0] lo,
                         input logic typed, input logic [63:0] ehi, input logic [63:0] elo,
                         input logic elast);
    dir_row_t row;
    row.ncb   = ncb;
    row.kp    = kp;
    row.bg2   = bg2;
    row.zc    = zc;
    row.hi    = hi;
    row.lo    = lo;
    row.typed = typed;
    row.tbeat = {ehi, elo, elast, 1'b1};
    dir_rows.push_back(row);
  endtask

  function automatic logic [63:0] rand_half();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 64'd0;
    if (pick == 1) return ONES;
    return {$urandom, $urandom};
  endfunction

  // Receiver: drive out_ready from one of four stall patterns, switching between them at random
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((rx_cycle % 8) < 5);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Check each accepted beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_beats.size() == 0) begin
        report_mismatch("beat with nothing queued", 64'd0, out_data_high);
      end else begin
        mon_want = exp_beats.pop_front();
        if (out_data_high !== mon_want.hi)
          report_mismatch("out_data_high", mon_want.hi, out_data_high);
        if (out_data_low !== mon_want.lo)
          report_mismatch("out_data_low", mon_want.lo, out_data_low);
        if (out_block_last !== mon_want.blast)
          report_mismatch("out_block_last", 64'(mon_want.blast), 64'(out_block_last));
        if (out_run_end !== mon_want.rend)
          report_mismatch("out_run_end", 64'(mon_want.rend), 64'(out_run_end));
      end
    end
  end

  // Stop the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("code_block_crc24_attach_top verification failed");
    $finish;
  end

  initial begin
    dir_row_t    row;
    int          ph, i, n_items, pause_at, pick;
    logic [5:0]  rn;
    logic [13:0] rk;
    logic        rb;
    logic [8:0]  rz;

    // Directed rows: reset settings, extremes, and each CRC placement case
    add_row(1, 8448, 0, 384, ONES, ONES, 1, ONES, ONES, 0);
    add_row(1, 8448, 0, 384, 64'd0, 64'd0, 1, 64'd0, 64'd0, 0);
    // shrink the block mid block: the stored word index makes this word final
    add_row(1, 128, 0, 2, ONES, 64'd0, 1, ONES, 64'd0, 1);
    add_row(1, 128, 0, 2, 64'd0, ONES, 1, 64'd0, ONES, 1);
    add_row(0, 0, 1, 384, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 0, 0, 0, 0);
    add_row(0, 25, 1, 384, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    // empty payload: the CRC of no bits is zero
    add_row(2, 24, 0, 2, ONES, ONES, 1, 64'd0, 64'd0, 1);
    add_row(2, 152, 0, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(2, 280, 0, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(2, 280, 0, 2, ONES, ONES, 0, 0, 0, 0);
    add_row(3, 142, 0, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(3, 142, 0, 2, ONES, ONES, 0, 0, 0, 0);
    add_row(3, 142, 0, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(63, 124, 0, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(63, 128, 0, 2, ONES, ONES, 0, 0, 0, 0);
    add_row(63, 151, 0, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(63, 16383, 1, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(63, 16383, 1, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    // CRC mode, block cut short with a partial remainder carried in
    add_row(2, 300, 0, 2, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    // full CRC spill plus saturated filler: the longest run
    add_row(2, 152, 0, 384, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(5, 200, 1, 511, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);
    add_row(5, 200, 0, 0, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed rows
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if ({row.ncb, row.kp, row.bg2, row.zc} != {ncb_q, kp_q, bg2_q, zc_q})
        set_config(row.ncb, row.kp, row.bg2, row.zc);
      send_word(row.hi, row.lo, row.typed, row.tbeat);
    end

    // Random phases: mostly short CRC blocks, some sized near word boundaries
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) rn = 6'd0;
      else if (pick == 1) rn = 6'd1;
      else if (pick == 2) rn = 6'd63;
      else rn = 6'($urandom_range(2, 62));
      pick = $urandom_range(0, 9);
      if (pick == 0) rk = 14'd16383;
      else if (pick == 1) rk = 14'($urandom_range(25, 16383));
      else if (pick <= 4)
        rk = 14'(128 * $urandom_range(1, 4) + 24 - $urandom_range(0, 24));
      else rk = 14'($urandom_range(25, 600));
      rb = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 5);
      if (pick == 0) rz = 9'd384;
      else if (pick == 1) rz = 9'($urandom_range(2, 511));
      else rz = 9'($urandom_range(2, 40));
      set_config(rn, rk, rb, rz);

      n_items = PHASE_WORDS;
      pause_at = $urandom_range(0, n_items - 1);
      for (i = 0; i < n_items; i++) begin
        if (i == pause_at) wait_drain();
        send_word(rand_half(), rand_half(), 1'b0, '0);
      end
    end

    // Drain, then watch a short window for stray beats
    wait_drain();
    repeat (16) @(negedge clk);
    if (err_cnt == 0 && exp_beats.size() == 0) begin
      $display("code_block_crc24_attach_top verification clean");
    end else begin
      $display("code_block_crc24_attach_top verification failed");
    end
    $finish;
  end

endmodule
